// File: sv/glyph_rotate_pixel_expander_assert.svh
// assertion macros for the glyph rotate pixel expander
// used by grpe_back to check its own control logic; no other dependencies
`ifndef GLYPH_ROTATE_PIXEL_EXPANDER_ASSERT_SVH
`define GLYPH_ROTATE_PIXEL_EXPANDER_ASSERT_SVH
`ifndef SYNTHESIS
`define GRPE_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
    else $error("grpe check failed: same cycle");
`define GRPE_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
    else $error("grpe check failed: next cycle");
`else
`define GRPE_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons)
`define GRPE_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons)
`endif
`endif

// File: sv/grpe_pkg.sv
// shared types and constants for the glyph rotate pixel expander
// no dependencies
`timescale 1ns / 1ps

package grpe_pkg;

  localparam int DEF_MAX_GLYPH_SIDE = 255;
  localparam int DEF_COORD_BITS     = 12;

  localparam int ORIGIN_W    = 12;
  localparam int SIDE_W      = 8;
  localparam int PIX_W       = 13;
  localparam int COLOR_W     = 4;
  localparam int BYTE_W      = 8;
  localparam int BIT_IDX_W   = 3;
  localparam int COL_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COLOR_W-1:0] FG_COLOR_RST  = 4'd0;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST  = 4'd15;
  localparam logic               BG_TRANSP_RST = 1'b1;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG_COLOR  = 2'd0,
    CFG_BG_COLOR  = 2'd1,
    CFG_BG_TRANSP = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                glyph_start;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [SIDE_W-1:0]   glyph_width;
    logic [SIDE_W-1:0]   glyph_height;
    rot_t                rotation;
    logic [BYTE_W-1:0]   bitmap_byte;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_of_byte;
  } out_item_t;

  // one classified byte: fixed coordinate, start of the stepping one, and
  // the bits that give a write (index 0 is the leftmost pixel)
  typedef struct packed {
    logic [PIX_W-1:0]  fix_coord;
    logic [PIX_W-1:0]  var_start;
    logic              var_on_y;
    logic              var_down;
    logic [BYTE_W-1:0] write_mask;
    logic [BYTE_W-1:0] set_bits;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] background_color;
  } colors_t;

endpackage

// File: sv/grpe_front.sv
// front end: accepts bitmap bytes, tracks glyph position, classifies each byte
// depends on grpe_pkg
`timescale 1ns / 1ps

module grpe_front import grpe_pkg::*; #(
  parameter int MAX_GLYPH_SIDE = DEF_MAX_GLYPH_SIDE,
  parameter int COORD_BITS     = DEF_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  logic      skip_clear,
  input  q_status_t q_status,
  output logic      q_push,
  output desc_t     q_data
);

  localparam int BASE_W = (COORD_BITS < ORIGIN_W) ? COORD_BITS : ORIGIN_W;
  localparam logic [SIDE_W-1:0] SIDE_LIM =
    (MAX_GLYPH_SIDE < (2 ** SIDE_W)) ? SIDE_W'(MAX_GLYPH_SIDE) : {SIDE_W{1'b1}};

  logic              active_r, active_nxt;
  logic [SIDE_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [BASE_W-1:0] base_x_r, base_y_r;
  logic [SIDE_W-1:0] width_r, height_r;
  rot_t              rot_r;

  logic              start, accept, eff_active;
  logic [BASE_W-1:0] eff_bx, eff_by;
  logic [SIDE_W-1:0] eff_w, eff_h, eff_row, in_w, in_h, dx0_8, rem;
  logic [COL_W-1:0]  eff_col;
  rot_t              eff_rot;
  logic [PIX_W-1:0]  bx, by, dy, dx0, w1, h1;
  logic [SIDE_W:0]   w_plus, row_inc;
  logic [COL_W:0]    bpr, col_inc;
  logic [BYTE_W-1:0] mask, bits;

  assign start  = in_data.glyph_start;
  assign accept = in_valid && in_ready;
  assign in_ready = !q_status.full;

  assign in_w = (int'(in_data.glyph_width) > MAX_GLYPH_SIDE) ? SIDE_LIM : in_data.glyph_width;
  assign in_h = (int'(in_data.glyph_height) > MAX_GLYPH_SIDE) ? SIDE_LIM : in_data.glyph_height;

  assign eff_w      = start ? in_w : width_r;
  assign eff_h      = start ? in_h : height_r;
  assign eff_bx     = start ? in_data.origin_x[BASE_W-1:0] : base_x_r;
  assign eff_by     = start ? in_data.origin_y[BASE_W-1:0] : base_y_r;
  assign eff_rot    = start ? in_data.rotation : rot_r;
  assign eff_row    = start ? '0 : row_r;
  assign eff_col    = start ? '0 : col_r;
  assign eff_active = start ? ((in_w != '0) && (in_h != '0)) : active_r;

  assign bx    = PIX_W'(eff_bx);
  assign by    = PIX_W'(eff_by);
  assign dy    = PIX_W'(eff_row);
  assign dx0_8 = {eff_col, {BIT_IDX_W{1'b0}}};
  assign dx0   = PIX_W'(dx0_8);
  assign w1    = PIX_W'(eff_w) - PIX_W'(1);
  assign h1    = PIX_W'(eff_h) - PIX_W'(1);
  assign rem   = eff_w - dx0_8;

  always_comb begin
    q_data = '0;
    unique case (eff_rot)
      ROT_0: begin
        q_data.fix_coord = by + dy;
        q_data.var_start = bx + dx0;
        q_data.var_on_y  = 1'b0;
        q_data.var_down  = 1'b0;
      end
      ROT_90: begin
        q_data.fix_coord = bx + h1 - dy;
        q_data.var_start = by + dx0;
        q_data.var_on_y  = 1'b1;
        q_data.var_down  = 1'b0;
      end
      ROT_180: begin
        q_data.fix_coord = by + h1 - dy;
        q_data.var_start = bx + w1 - dx0;
        q_data.var_on_y  = 1'b0;
        q_data.var_down  = 1'b1;
      end
      ROT_270: begin
        q_data.fix_coord = bx + dy;
        q_data.var_start = by + w1 - dx0;
        q_data.var_on_y  = 1'b1;
        q_data.var_down  = 1'b1;
      end
      default: ;
    endcase
    q_data.write_mask = mask;
    q_data.set_bits   = bits;
  end

  // msb first; padding bits past the width and transparent clear bits drop out
  always_comb begin
    for (int b = 0; b < BYTE_W; b++) begin
      bits[b] = in_data.bitmap_byte[BYTE_W-1-b];
      mask[b] = (SIDE_W'(b) < rem) && (bits[b] || !skip_clear);
    end
  end

  assign q_push = accept && eff_active && (|mask);

  assign w_plus  = {1'b0, eff_w} + (SIDE_W+1)'(BYTE_W - 1);
  assign bpr     = (COL_W+1)'(w_plus[SIDE_W:BIT_IDX_W]);
  assign col_inc = {1'b0, eff_col} + (COL_W+1)'(1);
  assign row_inc = {1'b0, eff_row} + (SIDE_W+1)'(1);

  always_comb begin
    active_nxt = 1'b0;
    row_nxt    = '0;
    col_nxt    = '0;
    if (eff_active) begin
      active_nxt = 1'b1;
      row_nxt    = eff_row;
      col_nxt    = col_inc[COL_W-1:0];
      if (col_inc >= bpr) begin
        col_nxt = '0;
        if (row_inc >= {1'b0, eff_h}) begin
          active_nxt = 1'b0;
          row_nxt    = '0;
        end else begin
          row_nxt = row_inc[SIDE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
    end else if (accept) begin
      active_r <= active_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r <= '0;
      base_y_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      rot_r    <= ROT_0;
    end else if (accept && start) begin
      base_x_r <= eff_bx;
      base_y_r <= eff_by;
      width_r  <= eff_w;
      height_r <= eff_h;
      rot_r    <= eff_rot;
    end
  end

endmodule

// File: sv/grpe_queue.sv
// short queue of classified bytes between front and back ends
// depends on grpe_pkg
`timescale 1ns / 1ps

module grpe_queue import grpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  desc_t     push_data,
  input  logic      pop,
  output desc_t     pop_data,
  output q_status_t status
);

  desc_t             entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: sv/grpe_back.sv
// back end: walks each byte's write mask, one pixel write per cycle unless stalled
// depends on grpe_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "glyph_rotate_pixel_expander_assert.svh"

module grpe_back import grpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  colors_t   colors,
  input  q_status_t q_status,
  input  desc_t     q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  desc_t             cur_r;
  logic [BYTE_W-1:0] mask_r, mask_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic                 have, advance, last_pix, load;
  logic [BIT_IDX_W-1:0] sel;
  logic [BYTE_W-1:0]    lowest, mask_left;
  logic [PIX_W-1:0]     var_coord;

  assign have      = |mask_r;
  assign advance   = have && (!out_valid_r || out_ready);
  assign lowest    = mask_r & (~mask_r + BYTE_W'(1));
  assign mask_left = mask_r & ~lowest;
  assign last_pix  = (mask_left == '0);
  assign load      = !q_status.empty && (!have || (advance && last_pix));
  assign q_pop     = load;

  always_comb begin
    sel = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = BIT_IDX_W'(i);
    end
  end

  assign var_coord = cur_r.var_down ? (cur_r.var_start - PIX_W'(sel))
                                    : (cur_r.var_start + PIX_W'(sel));

  always_comb begin
    out_data_nxt.pixel_x      = cur_r.var_on_y ? cur_r.fix_coord : var_coord;
    out_data_nxt.pixel_y      = cur_r.var_on_y ? var_coord : cur_r.fix_coord;
    out_data_nxt.pixel_color  = cur_r.set_bits[sel] ? colors.fg_color
                                                    : colors.background_color;
    out_data_nxt.last_of_byte = last_pix;
  end

  always_comb begin
    mask_nxt = mask_r;
    if (load) mask_nxt = q_data.write_mask;
    else if (advance) mask_nxt = mask_left;
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_r <= q_data;
    if (advance) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stalled output keeps the remaining bits of the byte in place
  `GRPE_ASSERT_NEXT(a_stall_holds_mask, clk, rst_n, out_valid_r && !out_ready && have, $stable(mask_r))
  // each emitted write retires exactly one bit
  `GRPE_ASSERT_NEXT(a_one_bit_per_write, clk, rst_n, advance && !load, ($countones(mask_r) + 1) == $past($countones(mask_r)))
  // when a byte runs out, its final write sits in the output register marked last
  `GRPE_ASSERT_IMPL(a_end_marks_last, clk, rst_n, !have && $past(have), out_valid_r && out_data_r.last_of_byte)

endmodule

// File: sv/glyph_rotate_pixel_expander.sv
// top level of the rotated 1bpp glyph pixel expander: config registers and wiring
// depends on grpe_pkg, grpe_front, grpe_queue and grpe_back
`timescale 1ns / 1ps

// The block takes one glyph bitmap byte per transaction on the input channel and
// turns it into 0 to 8 pixel writes on the output channel, one write per cycle
// while out_ready does not stall the output. The writes of a byte, 8 for a full
// opaque byte, go out one pixel at a time through the single output register
// of the back end. The front end takes a byte every cycle while its two-entry
// queue has room, so the next bytes are classified while earlier writes are still
// going out. An accepted byte passes the queue entry and the back end's byte
// registers before its first write reaches the output register.
// Configuration writes take effect the next cycle and should be issued only while
// no glyph bytes are in flight.

module glyph_rotate_pixel_expander import grpe_pkg::*; #(
  parameter int MAX_GLYPH_SIDE = DEF_MAX_GLYPH_SIDE,
  parameter int COORD_BITS     = DEF_COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);

  logic [COLOR_W-1:0] fg_color_r, bg_color_r;
  logic               bg_transp_r;

  colors_t   colors;
  q_status_t q_status;
  logic      q_push, q_pop;
  desc_t     q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r  <= FG_COLOR_RST;
      bg_color_r  <= BG_COLOR_RST;
      bg_transp_r <= BG_TRANSP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FG_COLOR:  fg_color_r  <= cfg_wdata;
        CFG_BG_COLOR:  bg_color_r  <= cfg_wdata;
        CFG_BG_TRANSP: bg_transp_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign colors.fg_color         = fg_color_r;
  assign colors.background_color = bg_color_r;

  grpe_front #(
    .MAX_GLYPH_SIDE(MAX_GLYPH_SIDE),
    .COORD_BITS    (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .skip_clear(bg_transp_r),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  grpe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .status   (q_status)
  );

  grpe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .colors   (colors),
    .q_status (q_status),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
